### rtl/rcddm_pkg.sv
// ============================================================================
// RC differential drive mixer package
// Shared codes, constants and the request/response types of the trim unit.
// ============================================================================
package rcddm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_SIDE_SCALE = 2'd0;
  localparam logic [1:0] CFG_SPEED_DEADBAND = 2'd1;
  localparam logic [1:0] CFG_STEER_DEADBAND = 2'd2;

  // Pulse kinds carried on tuser.
  localparam logic ACT_STEER    = 1'b0;
  localparam logic ACT_THROTTLE = 1'b1;

  // Drive direction codes.
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_FORWARD  = 2'd1;
  localparam logic [1:0] DIR_BACKWARD = 2'd2;

  // Pulse timing in microseconds.
  localparam logic [11:0] CENTER_US     = 12'd1500;
  localparam logic [11:0] THR_FULL_HI   = 12'd1900;
  localparam logic [11:0] THR_FULL_LO   = 12'd1100;
  localparam logic [11:0] STEER_FULL_HI = 12'd2000;
  localparam logic [11:0] STEER_FULL_LO = 12'd1000;

  // PWM compare values.
  localparam logic [13:0] PWM_BASE_MIN = 14'd2000;
  localparam logic [13:0] PWM_FULL     = 14'd10000;

  // Steering span and Q1.16 unity.
  localparam logic [9:0]  STEER_SPAN = 10'd500;
  localparam logic [17:0] Q16_ONE    = 18'd65536;

  // Reset values of the configuration registers.
  localparam logic [16:0] MIN_SIDE_SCALE_RST = 17'd39322;
  localparam logic [7:0]  SPEED_DEADBAND_RST = 8'd50;
  localparam logic [7:0]  STEER_DEADBAND_RST = 8'd50;

  // Division by 500 is done as a shift by two and a division by 125.
  // The quotient estimate floor(y * 67108 / 2^23) is low by at most one.
  localparam logic [16:0] RECIP_125 = 17'd67108;
  localparam logic [6:0]  DIV_125   = 7'd125;

  // Request to the trim unit.
  typedef struct packed {
    logic        valid;
    logic [13:0] base;
    logic [8:0]  mag;
    logic [16:0] k;
  } trim_req_t;

  // Response of the trim unit.
  typedef struct packed {
    logic        done;
    logic [13:0] inner;
  } trim_rsp_t;

endpackage

### rtl/rc_differential_drive_mixer_core.sv
// ============================================================================
// RC differential drive mixer core
// Turns RC steering and throttle pulse widths into left and right PWM
// compare values and a drive direction.
// ============================================================================
// Usage:
//   The slave stream carries one pulse request: tdata holds the pulse width
//   in microseconds, tuser says steering (0) or throttle (1). A steering
//   request only updates the stored offset and gives no result. A throttle
//   request gives one result on the master stream: left PWM, right PWM and
//   direction packed in tdata.
//   Configuration writes (index, data) are taken in any cycle; they should
//   be made while no request is in flight.
//   A steering request only updates the offset. A throttle request with no
//   trim goes to the output state and then into the output register; with a
//   trim it first waits for the six sequencer steps of the trim unit, four
//   of which use the shared multiplier.
//   Throughput: one request at a time; s_axis_tready_o is high only while
//   the sequencer is idle.
//   The result sits in an output register, so the next request is accepted
//   while a result waits; a stalled receiver holds the block only when a
//   second result is ready to be written.
//   Reset clears the offset, the direction and the output valid, and sets
//   the configuration registers to their defaults.
// ============================================================================
module rc_differential_drive_mixer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] pulse_width
  input  logic [0:0]  s_axis_tuser_i,   // [0] action
  // Master stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [13:0] pwm_left, [27:14] pwm_right,
                                        // [29:28] direction
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  import rcddm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TRIM = 3'b010,
    S_OUT  = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  logic [16:0] min_scale_q;
  logic [7:0]  speed_db_q;
  logic [7:0]  steer_db_q;

  logic [9:0]  offset_q, offset_d;
  logic [1:0]  dir_q, dir_d;
  logic        trim_left_q, trim_left_d;
  logic [13:0] pend_left_q, pend_left_d;
  logic [13:0] pend_right_q, pend_right_d;
  logic [1:0]  pend_dir_q, pend_dir_d;

  logic        out_valid_q, out_valid_d;
  logic [13:0] out_left_q, out_right_q;
  logic [1:0]  out_dir_q;
  logic        out_load;

  logic        accept;
  logic        act;
  logic [11:0] pulse;
  logic [11:0] diff_up, diff_dn;
  logic [11:0] spd_hi, spd_lo, str_hi, str_lo;
  logic        thr_fwd, thr_bwd;
  logic [13:0] base_fwd, base_bwd, base;
  logic [9:0]  steer_new;
  logic [9:0]  offset_neg;
  logic [8:0]  mag;
  logic [16:0] m_clamp;
  logic [16:0] k_cut;

  trim_req_t trim_req;
  trim_rsp_t trim_rsp;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign act             = s_axis_tuser_i[0];
  assign pulse           = s_axis_tdata_i[11:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_scale_q <= MIN_SIDE_SCALE_RST;
      speed_db_q  <= SPEED_DEADBAND_RST;
      steer_db_q  <= STEER_DEADBAND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_SIDE_SCALE: min_scale_q <= cfg_data_i;
        CFG_SPEED_DEADBAND: speed_db_q  <= cfg_data_i[7:0];
        CFG_STEER_DEADBAND: steer_db_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Deadband thresholds and distances from center.
  assign spd_hi  = CENTER_US + {4'b0, speed_db_q};
  assign spd_lo  = CENTER_US - {4'b0, speed_db_q};
  assign str_hi  = CENTER_US + {4'b0, steer_db_q};
  assign str_lo  = CENTER_US - {4'b0, steer_db_q};
  assign diff_up = pulse - CENTER_US;
  assign diff_dn = CENTER_US - pulse;

  // Throttle: base PWM is 2000 + 20 * distance, full at the endpoints.
  assign thr_fwd  = (pulse > spd_hi);
  assign thr_bwd  = (pulse < spd_lo);
  assign base_fwd = (pulse >= THR_FULL_HI) ? PWM_FULL :
                    PWM_BASE_MIN + {1'b0, diff_up[8:0], 4'b0} + {3'b0, diff_up[8:0], 2'b0};
  assign base_bwd = (pulse <= THR_FULL_LO) ? PWM_FULL :
                    PWM_BASE_MIN + {1'b0, diff_dn[8:0], 4'b0} + {3'b0, diff_dn[8:0], 2'b0};
  assign base     = thr_fwd ? base_fwd : base_bwd;

  // Steering: signed offset, clamped to the span, zero in the deadband.
  always_comb begin
    if (pulse > str_hi) begin
      steer_new = (pulse >= STEER_FULL_HI) ? STEER_SPAN : diff_up[9:0];
    end else if (pulse < str_lo) begin
      steer_new = (pulse <= STEER_FULL_LO) ? (10'd0 - STEER_SPAN) : (10'd0 - diff_dn[9:0]);
    end else begin
      steer_new = '0;
    end
  end

  // Trim operands: offset magnitude and the cut at full steer.
  assign offset_neg = 10'd0 - offset_q;
  assign mag        = offset_q[9] ? offset_neg[8:0] : offset_q[8:0];
  assign m_clamp    = ({1'b0, min_scale_q} > Q16_ONE) ? 17'(Q16_ONE) : min_scale_q;
  assign k_cut      = 17'(Q16_ONE - {1'b0, m_clamp});

  assign trim_req.valid = accept & (act == ACT_THROTTLE) & (thr_fwd | thr_bwd)
                          & (offset_q != '0);
  assign trim_req.base  = base;
  assign trim_req.mag   = mag;
  assign trim_req.k     = k_cut;

  rcddm_trim_unit u_trim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trim_req),
    .rsp_o  (trim_rsp)
  );

  // Output register is free or being emptied this cycle.
  assign out_load = (state_q == S_OUT) & (~out_valid_q | m_axis_tready_i);

  // Control sequencer.
  always_comb begin
    state_d      = state_q;
    offset_d     = offset_q;
    dir_d        = dir_q;
    trim_left_d  = trim_left_q;
    pend_left_d  = pend_left_q;
    pend_right_d = pend_right_q;
    pend_dir_d   = pend_dir_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (act == ACT_STEER) begin
            offset_d = steer_new;
          end else if (thr_fwd | thr_bwd) begin
            dir_d        = thr_fwd ? DIR_FORWARD : DIR_BACKWARD;
            pend_left_d  = base;
            pend_right_d = base;
            pend_dir_d   = thr_fwd ? DIR_FORWARD : DIR_BACKWARD;
            trim_left_d  = ~offset_q[9];
            state_d      = (offset_q != '0) ? S_TRIM : S_OUT;
          end else begin
            pend_left_d  = '0;
            pend_right_d = '0;
            pend_dir_d   = dir_q;
            state_d      = S_OUT;
          end
        end
      end
      S_TRIM: begin
        if (trim_rsp.done) begin
          if (trim_left_q) begin
            pend_left_d = trim_rsp.inner;
          end else begin
            pend_right_d = trim_rsp.inner;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid tracking.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      offset_q    <= '0;
      dir_q       <= DIR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      offset_q    <= offset_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pending result and output payload.
  always_ff @(posedge clk_i) begin
    trim_left_q  <= trim_left_d;
    pend_left_q  <= pend_left_d;
    pend_right_q <= pend_right_d;
    pend_dir_q   <= pend_dir_d;
    if (out_load) begin
      out_left_q  <= pend_left_q;
      out_right_q <= pend_right_q;
      out_dir_q   <= pend_dir_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b0, out_dir_q, out_right_q, out_left_q};

endmodule

### rtl/rcddm_trim_unit.sv
// ============================================================================
// RC differential drive mixer trim unit
// Computes floor(base * (65536 - floor(mag * k / 500)) / 65536) with one
// shared registered multiplier driven by a small sequencer.
// ============================================================================
module rcddm_trim_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcddm_pkg::trim_req_t req_i,
  output rcddm_pkg::trim_rsp_t rsp_o
);
  import rcddm_pkg::*;

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001,
    T_MK   = 7'b0000010,
    T_MR   = 7'b0000100,
    T_MQ   = 7'b0001000,
    T_MC   = 7'b0010000,
    T_MS   = 7'b0100000,
    T_DONE = 7'b1000000
  } trim_state_e;

  trim_state_e state_q, state_d;

  logic [13:0] base_q, base_d;
  logic [8:0]  mag_q, mag_d;
  logic [16:0] k_q, k_d;
  logic [39:0] prod_q, prod_d;
  logic [22:0] y_q, y_d;
  logic [16:0] q_q, q_d;
  logic [16:0] scale_q, scale_d;

  logic [22:0] mul_a;
  logic [16:0] mul_b;
  logic [39:0] mul_p;
  logic [22:0] rem;
  logic [16:0] q_fix;

  // Shared multiplier.
  assign mul_p = {17'b0, mul_a} * {23'b0, mul_b};

  // Remainder check and quotient correction.
  assign rem   = y_q - prod_q[22:0];
  assign q_fix = q_q + ((rem >= {16'b0, DIV_125}) ? 17'd1 : 17'd0);

  // Sequencer: at most one multiplier operation per step.
  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    mag_d   = mag_q;
    k_d     = k_q;
    prod_d  = prod_q;
    y_d     = y_q;
    q_d     = q_q;
    scale_d = scale_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      T_IDLE: begin
        if (req_i.valid) begin
          base_d  = req_i.base;
          mag_d   = req_i.mag;
          k_d     = req_i.k;
          state_d = T_MK;
        end
      end
      T_MK: begin
        // Product of steering magnitude and the full-steer cut.
        mul_a   = {14'b0, mag_q};
        mul_b   = k_q;
        prod_d  = mul_p;
        state_d = T_MR;
      end
      T_MR: begin
        // Divide by four, then estimate the quotient by 125.
        y_d     = prod_q[24:2];
        mul_a   = prod_q[24:2];
        mul_b   = RECIP_125;
        prod_d  = mul_p;
        state_d = T_MQ;
      end
      T_MQ: begin
        // Multiply the estimate back to get the remainder.
        q_d     = prod_q[39:23];
        mul_a   = {6'b0, prod_q[39:23]};
        mul_b   = {10'b0, DIV_125};
        prod_d  = mul_p;
        state_d = T_MC;
      end
      T_MC: begin
        // Correct the quotient and form the Q1.16 scale.
        scale_d = 17'(Q16_ONE - {1'b0, q_fix});
        state_d = T_MS;
      end
      T_MS: begin
        mul_a   = {9'b0, base_q};
        mul_b   = scale_q;
        prod_d  = mul_p;
        state_d = T_DONE;
      end
      T_DONE: begin
        state_d = T_IDLE;
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    mag_q   <= mag_d;
    k_q     <= k_d;
    prod_q  <= prod_d;
    y_q     <= y_d;
    q_q     <= q_d;
    scale_q <= scale_d;
  end

  // The scaled value never exceeds the base, so it fits 14 bits.
  assign rsp_o.done  = (state_q == T_DONE);
  assign rsp_o.inner = prod_q[29:16];

endmodule

### bench/tb_top.sv
// ============================================================================
// Testbench for the RC differential drive mixer core
// Streams steering and throttle pulse requests into the block and predicts
// the PWM and direction result of every throttle request. Each result on the
// master stream is checked field by field against the prediction. Both
// streams stall at random, and the configuration registers are rewritten
// between phases while the block is idle.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
  import rcddm_pkg::*;

  // Integer copies of the pulse timing and PWM constants.
  localparam int CENTER     = int'(CENTER_US);
  localparam int THR_HI     = int'(THR_FULL_HI);
  localparam int THR_LO     = int'(THR_FULL_LO);
  localparam int STR_HI     = int'(STEER_FULL_HI);
  localparam int STR_LO     = int'(STEER_FULL_LO);
  localparam int BASE_MIN   = int'(PWM_BASE_MIN);
  localparam int FULL       = int'(PWM_FULL);
  localparam int SPAN       = int'(STEER_SPAN);
  localparam int ONE        = int'(Q16_ONE);
  localparam int PWM_PER_US = 20;

  // Register index that selects no register.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 20;
  localparam int SETTLE_LIMIT    = 50000;

  typedef struct packed {
    logic        act;
    logic [11:0] pulse;
  } pulse_req_t;

  // Same layout as the master tdata, lowest field last.
  typedef struct packed {
    logic [1:0]  dir;
    logic [13:0] right;
    logic [13:0] left;
  } mix_result_t;

  // Directed requests: deadbands, saturation points and steering extremes.
  localparam logic [12:0] DIRECTED [23] = '{
    {ACT_THROTTLE, 12'd1500},  // deadband before any direction is set
    {ACT_THROTTLE, 12'd0},
    {ACT_THROTTLE, 12'd1550},  // deadband keeps backward
    {ACT_THROTTLE, 12'd4095},
    {ACT_STEER,    12'd4095},
    {ACT_THROTTLE, 12'd1900},
    {ACT_STEER,    12'd0},
    {ACT_THROTTLE, 12'd1899},
    {ACT_THROTTLE, 12'd1100},
    {ACT_STEER,    12'd1999},
    {ACT_THROTTLE, 12'd1101},
    {ACT_STEER,    12'd1001},
    {ACT_THROTTLE, 12'd1551},
    {ACT_STEER,    12'd1551},
    {ACT_THROTTLE, 12'd1449},
    {ACT_STEER,    12'd1550},
    {ACT_THROTTLE, 12'd1450},
    {ACT_STEER,    12'd1449},
    {ACT_THROTTLE, 12'd2048},
    {ACT_STEER,    12'd1000},
    {ACT_THROTTLE, 12'd1000},
    {ACT_STEER,    12'd2000},
    {ACT_THROTTLE, 12'd1700}
  };

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        s_valid = 1'b0;
  pulse_req_t  cur_req = '0;
  logic        m_ready = 1'b1;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data  = '0;

  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_tdata;
  logic        cfg_ready;

  // Predictor state and its copy of the configuration.
  logic signed [9:0] steer_off = '0;
  logic [1:0]        drive_dir = DIR_NONE;
  logic [16:0]       scale_reg = MIN_SIDE_SCALE_RST;
  logic [7:0]        spd_db    = SPEED_DEADBAND_RST;
  logic [7:0]        str_db    = STEER_DEADBAND_RST;

  pulse_req_t  pending_reqs[$];
  mix_result_t expected_mix[$];
  int unsigned err_cnt = 0;
  logic        quiet = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  rc_differential_drive_mixer_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  ({4'b0, cur_req.pulse}),
    .s_axis_tuser_i  (cur_req.act),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk = ~clk;

  // Updates the steering offset or computes the mixed PWM of one request.
  function automatic void mix_pulse(logic act, logic [11:0] pulse);
    int p, db, base, mag, k, cut, inner;
    mix_result_t res;
    p = int'(pulse);
    if (act == ACT_STEER) begin
      db = int'(str_db);
      if (p > CENTER + db) begin
        steer_off = 10'((p >= STR_HI) ? SPAN : p - CENTER);
      end else if (p < CENTER - db) begin
        steer_off = 10'((p <= STR_LO) ? -SPAN : p - CENTER);
      end else begin
        steer_off = '0;
      end
      return;
    end
    db = int'(spd_db);
    if (p > CENTER + db) begin
      drive_dir = DIR_FORWARD;
      base = (p >= THR_HI) ? FULL : BASE_MIN + PWM_PER_US * (p - CENTER);
    end else if (p < CENTER - db) begin
      drive_dir = DIR_BACKWARD;
      base = (p <= THR_LO) ? FULL : BASE_MIN + PWM_PER_US * (CENTER - p);
    end else begin
      // Inside the deadband both motors stop and the direction is kept.
      base = 0;
    end
    res.left  = 14'(base);
    res.right = 14'(base);
    if (base != 0 && steer_off != 0) begin
      mag = (steer_off < 0) ? -steer_off : steer_off;
      k = ONE - ((scale_reg > ONE) ? ONE : int'(scale_reg));
      cut = (mag * k) / SPAN;
      inner = (base * (ONE - cut)) >>> 16;
      if (inner > FULL) inner = FULL;
      if (steer_off > 0) res.left = 14'(inner);
      else res.right = 14'(inner);
    end
    res.dir = drive_dir;
    expected_mix.push_back(res);
  endfunction

  // Request driver: takes the next pending request after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      in_gap  <= 0;
    end else begin
      if (s_valid && s_ready) mix_pulse(cur_req.act, cur_req.pulse);
      if (!s_valid || s_ready) begin
        if (in_gap != 0) begin
          s_valid <= 1'b0;
          in_gap  <= in_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          cur_req <= pending_reqs.pop_front();
          s_valid <= 1'b1;
          in_gap  <= quiet ? 0 : $urandom_range(0, 8);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and then stalls for a random time.
  always @(posedge clk) begin : result_mon
    mix_result_t got, want;
    int unsigned stall_n;
    if (!rst_n) begin
      m_ready   <= 1'b1;
      out_stall <= 0;
    end else if (m_valid && m_ready) begin
      got = m_tdata[29:0];
      if (expected_mix.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = expected_mix.pop_front();
        if (got.left !== want.left) begin
          $display("%0t: pwm_left mismatch, expected %0d, actual %0d",
                   $time, want.left, got.left);
          err_cnt++;
        end
        if (got.right !== want.right) begin
          $display("%0t: pwm_right mismatch, expected %0d, actual %0d",
                   $time, want.right, got.right);
          err_cnt++;
        end
        if (got.dir !== want.dir) begin
          $display("%0t: direction mismatch, expected %0d, actual %0d",
                   $time, want.dir, got.dir);
          err_cnt++;
        end
      end
      stall_n = quiet ? 0 : $urandom_range(0, 8);
      if (stall_n != 0) begin
        m_ready   <= 1'b0;
        out_stall <= stall_n;
      end
    end else if (!m_ready) begin
      if (out_stall <= 1) m_ready <= 1'b1;
      else out_stall <= out_stall - 1;
    end
  end

  // Writes one configuration register and mirrors it in the predictor.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_SIDE_SCALE: scale_reg = val;
      CFG_SPEED_DEADBAND: spd_db = val[7:0];
      CFG_STEER_DEADBAND: str_db = val[7:0];
      default: ;
    endcase
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic settle();
    int unsigned n;
    n = 0;
    while ((pending_reqs.size() != 0 || s_valid || expected_mix.size() != 0)
           && n < SETTLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_mix.size() != 0) begin
      $display("%0t: %0d results missing, expected %h first, actual none",
               $time, expected_mix.size(), expected_mix[0]);
      err_cnt++;
      expected_mix.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main sequence: reset, directed requests, then random phases.
  initial begin : main_seq
    logic [16:0] sc;
    logic [7:0]  sd, td;
    pulse_req_t  req;
    int          db;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    foreach (DIRECTED[i]) pending_reqs.push_back(pulse_req_t'(DIRECTED[i]));
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin sc = 17'd0;      sd = 8'd0;   td = 8'd0;   end
        1: begin sc = 17'd65536;  sd = 8'd255; td = 8'd255; end
        2: begin sc = 17'd131071; sd = 8'd0;   td = 8'd255; end
        3: begin sc = 17'($urandom_range(65537, 131071)); sd = 8'd255; td = 8'd0; end
        default: begin
          case ($urandom_range(0, 3))
            0: sc = 17'($urandom_range(0, 65536));
            1: sc = MIN_SIDE_SCALE_RST;
            2: sc = 17'($urandom_range(65537, 131071));
            default: sc = 17'($urandom_range(60000, 65536));
          endcase
          sd = 8'($urandom_range(0, 255));
          td = 8'($urandom_range(0, 255));
        end
      endcase
      // Upper data bits of the deadband writes are junk and must be dropped.
      write_reg(CFG_MIN_SIDE_SCALE, sc);
      write_reg(CFG_SPEED_DEADBAND, {9'($urandom), sd});
      write_reg(CFG_STEER_DEADBAND, {9'($urandom), td});
      write_reg(CFG_UNUSED, 17'($urandom));

      @(negedge clk);
      quiet = (ph == 2 || ph == 5);
      repeat (ITEMS_PER_PHASE) begin
        req.act = ($urandom_range(0, 99) < 55) ? ACT_THROTTLE : ACT_STEER;
        db = (req.act == ACT_THROTTLE) ? int'(spd_db) : int'(str_db);
        case ($urandom_range(0, 9))
          0, 1: req.pulse = 12'($urandom_range(0, 4095));
          2, 3: begin
            // Points just on either side of a threshold.
            case ($urandom_range(0, 5))
              0: req.pulse = 12'(CENTER + db + $urandom_range(0, 1));
              1: req.pulse = 12'(CENTER - db - $urandom_range(0, 1));
              2: req.pulse = 12'(THR_LO + $urandom_range(0, 1));
              3: req.pulse = 12'(THR_HI - 1 + $urandom_range(0, 1));
              4: req.pulse = 12'(STR_LO + $urandom_range(0, 1));
              default: req.pulse = 12'(STR_HI - 1 + $urandom_range(0, 1));
            endcase
          end
          4: req.pulse = 12'($urandom_range(CENTER - db, CENTER + db));
          default: req.pulse = 12'($urandom_range(900, 2100));
        endcase
        pending_reqs.push_back(req);
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
